[src/bsct_pkg.sv]
package bsct_pkg;

   // display / control mode of the timer
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_SET_SEC  = 3'd1,
      MODE_SET_MIN  = 3'd2,
      MODE_COUNTING = 3'd3,
      MODE_PAUSED   = 3'd4,
      MODE_ALARM    = 3'd5
   } mode_type;

   // configuration register indexes
   localparam logic [1:0] CSR_HOLD_TICKS       = 2'd0;
   localparam logic [1:0] CSR_RESET_HOLD_TICKS = 2'd1;
   localparam logic [1:0] CSR_FAST_STEP        = 2'd2;

   localparam logic [7:0] HOLD_TICKS_RESET       = 8'd1;
   localparam logic [7:0] RESET_HOLD_TICKS_RESET = 8'd1;
   localparam logic [5:0] FAST_STEP_RESET        = 6'd5;

   localparam logic [5:0] TIME_TOP  = 6'd59;
   localparam logic [6:0] TIME_WRAP = 7'd60;
   localparam logic [7:0] HOLD_MAX  = 8'hFF;

   typedef struct packed {
      logic [7:0] hold_ticks;
      logic [7:0] reset_hold_ticks;
      logic [5:0] fast_step;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic [5:0] min_count;
      logic [5:0] sec_count;
      logic       running;
      logic       paused_flag;
      logic       sec_btn_seen;
      logic       min_btn_seen;
      logic       sec_fast;
      logic       min_fast;
      logic [7:0] sec_hold_count;
      logic [7:0] min_hold_count;
      logic       combo_seen;
      logic [7:0] combo_count;
      logic       blink_phase;
      logic       led_run;
      logic       led_alarm;
   } state_type;

   typedef struct packed {
      logic       fast_minutes_on;
      logic       fast_seconds_on;
      logic       all_buttons;
      logic       start_refused;
      logic       led_alarm;
      logic       led_run;
      logic [5:0] seconds_now;
      logic [5:0] minutes_now;
      mode_type   mode;
   } rsp_type;

   // add modulo 60, operand below 60 and step below 64
   function automatic logic [5:0] wrap_add(logic [5:0] val, logic [5:0] by);
      logic [6:0] sum;
      sum = {1'b0, val} + {1'b0, by};
      if (sum >= (TIME_WRAP << 1)) begin
         sum = sum - (TIME_WRAP << 1);
      end else if (sum >= TIME_WRAP) begin
         sum = sum - TIME_WRAP;
      end
      return sum[5:0];
   endfunction

   // drop all button hold tracking
   function automatic state_type clear_holds(state_type s);
      state_type r;
      r = s;
      r.sec_hold_count = '0;
      r.min_hold_count = '0;
      r.sec_fast       = 1'b0;
      r.min_fast       = 1'b0;
      r.sec_btn_seen   = 1'b0;
      r.min_btn_seen   = 1'b0;
      r.combo_seen     = 1'b0;
      r.combo_count    = '0;
      return r;
   endfunction

endpackage

[src/bsct_core.sv]
module bsct_core (
   input  bsct_pkg::state_type state_i,
   input  bsct_pkg::cfg_type   cfg_i,
   input  logic                action,
   input  logic                btn_seconds,
   input  logic                btn_minutes,
   input  logic                btn_pause,
   output bsct_pkg::state_type state_o,
   output bsct_pkg::rsp_type   rsp_o
);
   import bsct_pkg::*;

   state_type st;
   logic      may_set;
   logic      refused;
   logic      all3;
   logic      fs_on;
   logic      fm_on;

   // next state for one request
   always_comb begin
      st      = state_i;
      may_set = (state_i.mode != MODE_COUNTING) && (state_i.mode != MODE_PAUSED);
      refused = 1'b0;
      all3    = 1'b0;
      fs_on   = 1'b0;
      fm_on   = 1'b0;

      if (!action) begin
         // button poll
         if (btn_seconds && btn_minutes && btn_pause) begin
            all3 = 1'b1;
            st   = clear_holds(st);
         end else if (btn_seconds && btn_minutes) begin
            if (!st.combo_seen) begin
               st.combo_seen  = 1'b1;
               st.combo_count = '0;
            end
         end else if (btn_seconds && !btn_pause) begin
            if (may_set) begin
               st.mode = MODE_SET_SEC;
               if (!st.sec_btn_seen) begin
                  st.sec_count      = wrap_add(st.sec_count, 6'd1);
                  st.sec_btn_seen   = 1'b1;
                  st.sec_hold_count = '0;
                  st.sec_fast       = 1'b0;
               end else if (!st.sec_fast) begin
                  st.sec_count      = wrap_add(st.sec_count, 6'd1);
                  st.sec_hold_count = '0;
               end
            end
         end else if (btn_minutes && !btn_pause) begin
            if (may_set) begin
               st.mode = MODE_SET_MIN;
               if (!st.min_btn_seen) begin
                  st.min_count      = wrap_add(st.min_count, 6'd1);
                  st.min_btn_seen   = 1'b1;
                  st.min_hold_count = '0;
                  st.min_fast       = 1'b0;
               end else if (!st.min_fast) begin
                  st.min_count      = wrap_add(st.min_count, 6'd1);
                  st.min_hold_count = '0;
               end
            end
         end else if (btn_pause && !btn_seconds && !btn_minutes) begin
            if (st.mode == MODE_COUNTING) begin
               st.paused_flag = 1'b1;
               st.mode        = MODE_PAUSED;
            end else if (st.mode == MODE_PAUSED) begin
               st.paused_flag = 1'b0;
               st.mode        = MODE_COUNTING;
            end
            st = clear_holds(st);
         end else begin
            st = clear_holds(st);
         end
      end else begin
         // one-second tick
         st.blink_phase = !st.blink_phase;

         // fast stepping on the seconds button
         if (btn_seconds && st.sec_btn_seen && may_set) begin
            if (st.sec_hold_count != HOLD_MAX) begin
               st.sec_hold_count = st.sec_hold_count + 8'd1;
            end
            if ((st.sec_hold_count >= cfg_i.hold_ticks) && !st.sec_fast) begin
               st.sec_fast = 1'b1;
               fs_on       = 1'b1;
            end
            if (st.sec_fast) begin
               st.sec_count = wrap_add(st.sec_count, cfg_i.fast_step);
            end
         end

         // fast stepping on the minutes button
         if (btn_minutes && st.min_btn_seen && may_set) begin
            if (st.min_hold_count != HOLD_MAX) begin
               st.min_hold_count = st.min_hold_count + 8'd1;
            end
            if ((st.min_hold_count >= cfg_i.hold_ticks) && !st.min_fast) begin
               st.min_fast = 1'b1;
               fm_on       = 1'b1;
            end
            if (st.min_fast) begin
               st.min_count = wrap_add(st.min_count, cfg_i.fast_step);
            end
         end

         // start / reset combination
         if (btn_seconds && btn_minutes && !btn_pause) begin
            if (st.combo_seen) begin
               if (st.combo_count != HOLD_MAX) begin
                  st.combo_count = st.combo_count + 8'd1;
               end
               if (st.combo_count >= cfg_i.reset_hold_ticks) begin
                  st.min_count   = '0;
                  st.sec_count   = '0;
                  st.mode        = MODE_IDLE;
                  st.running     = 1'b0;
                  st.paused_flag = 1'b0;
                  st             = clear_holds(st);
               end
            end
         end else begin
            if (st.combo_seen && (st.combo_count < cfg_i.reset_hold_ticks) &&
                (st.mode == MODE_IDLE || st.mode == MODE_SET_SEC ||
                 st.mode == MODE_SET_MIN)) begin
               if (st.min_count == '0 && st.sec_count == '0) begin
                  refused = 1'b1;
               end else begin
                  st.running     = 1'b1;
                  st.paused_flag = 1'b0;
                  st.mode        = MODE_COUNTING;
                  st             = clear_holds(st);
               end
            end
            st.combo_seen  = 1'b0;
            st.combo_count = '0;
         end

         // countdown
         if (st.running && !st.paused_flag) begin
            if (st.sec_count != '0) begin
               st.sec_count = st.sec_count - 6'd1;
            end else if (st.min_count != '0) begin
               st.min_count = st.min_count - 6'd1;
               st.sec_count = TIME_TOP;
            end else begin
               st.running = 1'b0;
               st.mode    = MODE_ALARM;
               st         = clear_holds(st);
            end
         end

         // leds
         if (st.mode == MODE_COUNTING) begin
            st.led_run   = !st.blink_phase;
            st.led_alarm = 1'b0;
         end else if (st.mode == MODE_ALARM) begin
            st.led_run = 1'b1;
            if (!st.blink_phase) begin
               st.led_alarm = !st.led_alarm;
            end
         end else begin
            st.led_run   = 1'b0;
            st.led_alarm = 1'b0;
         end
      end
   end

   assign state_o = st;

   // result fields
   always_comb begin
      rsp_o.mode            = st.mode;
      rsp_o.minutes_now     = st.min_count;
      rsp_o.seconds_now     = st.sec_count;
      rsp_o.led_run         = st.led_run;
      rsp_o.led_alarm       = st.led_alarm;
      rsp_o.start_refused   = refused;
      rsp_o.all_buttons     = all3;
      rsp_o.fast_seconds_on = fs_on;
      rsp_o.fast_minutes_on = fm_on;
   end

endmodule

[src/button_set_countdown_timer.sv]
// throughput: one request per cycle while the output register is empty or
//   being taken; the timer state is updated in the same cycle the request is
//   accepted and the result waits in an output register, on rsp_tdata in the cycle after
// reset: synchronous, active high; time 00:00, mode idle, leds off,
//   hold_ticks = 1, reset_hold_ticks = 1, fast_step = 5
module button_set_countdown_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // btn_seconds, btn_minutes, btn_pause, zero pad
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mode[2:0], minutes_now[8:3], seconds_now[14:9], led_run, led_alarm,
   // start_refused, all_buttons, fast_seconds_on, fast_minutes_on, zero pad
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import bsct_pkg::*;

   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      req_accept;

   // output register frees up when taken or empty
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   bsct_core u_core (
      .state_i     (state_ff),
      .cfg_i       (cfg_ff),
      .action      (req_tuser),
      .btn_seconds (req_tdata[0]),
      .btn_minutes (req_tdata[1]),
      .btn_pause   (req_tdata[2]),
      .state_o     (state_in),
      .rsp_o       (rsp_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks       <= HOLD_TICKS_RESET;
         cfg_ff.reset_hold_ticks <= RESET_HOLD_TICKS_RESET;
         cfg_ff.fast_step        <= FAST_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOLD_TICKS:       cfg_ff.hold_ticks       <= csr_wdata;
            CSR_RESET_HOLD_TICKS: cfg_ff.reset_hold_ticks <= csr_wdata;
            CSR_FAST_STEP:        cfg_ff.fast_step        <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // timer state, all zero is 00:00 in idle mode
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

   // time stays within 00:00 .. 59:59
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.min_count <= TIME_TOP) && (state_ff.sec_count <= TIME_TOP))
      else $error("time value out of range");

   // running exactly while counting or paused
   assert property (@(posedge clock) disable iff (reset)
      state_ff.running == (state_ff.mode == MODE_COUNTING || state_ff.mode == MODE_PAUSED))
      else $error("running flag disagrees with mode");

   // paused flag tracks the paused mode
   assert property (@(posedge clock) disable iff (reset)
      state_ff.paused_flag == (state_ff.mode == MODE_PAUSED))
      else $error("paused flag disagrees with mode");

   // every accepted request leaves a result
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted request produced no result");

endmodule

[tb/sv/tb_button_set_countdown_timer.sv]
`timescale 1ns / 100ps

module tb_button_set_countdown_timer;
   import bsct_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_STALL  = 300;
   localparam int END_SETTLE  = 10;
   localparam int CSR_SETTLE  = 3;

   // request kinds and button levels {pause, minutes, seconds}
   localparam logic       ACT_POLL  = 1'b0;
   localparam logic       ACT_TICK  = 1'b1;
   localparam logic [2:0] BTN_NONE  = 3'b000;
   localparam logic [2:0] BTN_SEC   = 3'b001;
   localparam logic [2:0] BTN_MIN   = 3'b010;
   localparam logic [2:0] BTN_COMBO = 3'b011;
   localparam logic [2:0] BTN_PAUSE = 3'b100;
   localparam logic [2:0] BTN_ALL   = 3'b111;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // btn_seconds, btn_minutes, btn_pause, zero pad
   logic        req_tuser = 1'b0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // mode[2:0], minutes_now[8:3], seconds_now[14:9], led_run, led_alarm,
   // start_refused, all_buttons, fast_seconds_on, fast_minutes_on, zero pad
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_wdata = 8'd0;

   button_set_countdown_timer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // timer model state and its copy of the registers
   mode_type   m_mode;
   logic [5:0] m_min, m_sec;
   logic       m_running, m_paused;
   logic       m_sec_seen, m_min_seen, m_sec_fast, m_min_fast;
   logic [7:0] m_sec_hold, m_min_hold;
   logic       m_combo_seen;
   logic [7:0] m_combo_cnt;
   logic       m_blink, m_led_run, m_led_alarm;
   logic [7:0] cfg_hold, cfg_reset_hold;
   logic [5:0] cfg_step;

   rsp_type pending_readouts[$];
   int      fail_count = 0;
   int      requests_sent = 0;
   int      cycle_count = 0;
   int      burst_left = 0;

   // receiver control
   logic         long_stall_go = 1'b0;
   int           stall_left = 0;
   int           style_left = 0;
   rx_style_type rx_style = RX_OPEN;
   logic [15:0]  ready_pattern = 16'h8001;

   function automatic logic [5:0] add_mod60(logic [5:0] v, logic [5:0] by);
      int s;
      s = int'(v) + int'(by);
      return 6'(s % 60);
   endfunction

   function automatic logic setting_allowed();
      return m_mode != MODE_COUNTING && m_mode != MODE_PAUSED;
   endfunction

   task automatic clear_tracking();
      m_sec_hold   = 8'd0;
      m_min_hold   = 8'd0;
      m_sec_fast   = 1'b0;
      m_min_fast   = 1'b0;
      m_sec_seen   = 1'b0;
      m_min_seen   = 1'b0;
      m_combo_seen = 1'b0;
      m_combo_cnt  = 8'd0;
   endtask

   task automatic reset_timer_model();
      cfg_hold       = HOLD_TICKS_RESET;
      cfg_reset_hold = RESET_HOLD_TICKS_RESET;
      cfg_step       = FAST_STEP_RESET;
      m_mode         = MODE_IDLE;
      m_min          = 6'd0;
      m_sec          = 6'd0;
      m_running      = 1'b0;
      m_paused       = 1'b0;
      clear_tracking();
      m_blink        = 1'b0;
      m_led_run      = 1'b0;
      m_led_alarm    = 1'b0;
   endtask

   // single set button pressed on a poll
   task automatic step_setting(input mode_type nm, inout logic [5:0] val,
                               inout logic seen, inout logic [7:0] hold,
                               inout logic fast);
      if (setting_allowed()) begin
         m_mode = nm;
         if (!seen) begin
            val  = add_mod60(val, 6'd1);
            seen = 1'b1;
            hold = 8'd0;
            fast = 1'b0;
         end else if (!fast) begin
            val  = add_mod60(val, 6'd1);
            hold = 8'd0;
         end
      end
   endtask

   // held set button on a tick, may enter fast stepping
   task automatic hold_tick(input logic down, inout logic [5:0] val, input logic seen,
                            inout logic [7:0] hold, inout logic fast,
                            output logic began);
      began = 1'b0;
      if (down && seen && setting_allowed()) begin
         if (hold != HOLD_MAX) hold++;
         if (hold >= cfg_hold && !fast) begin
            fast  = 1'b1;
            began = 1'b1;
         end
         if (fast) val = add_mod60(val, cfg_step);
      end
   endtask

   // apply one accepted request to the model and queue the readout
   task automatic advance_timer(input logic tick, input logic [2:0] btn);
      rsp_type r;
      logic    b1, b2, b3, refused, all3, fs_on, fm_on;
      b1      = btn[0];
      b2      = btn[1];
      b3      = btn[2];
      refused = 1'b0;
      all3    = 1'b0;
      fs_on   = 1'b0;
      fm_on   = 1'b0;
      if (tick == ACT_POLL) begin
         if (b1 && b2 && b3) begin
            all3 = 1'b1;
            clear_tracking();
         end else if (b1 && b2) begin
            if (!m_combo_seen) begin
               m_combo_seen = 1'b1;
               m_combo_cnt  = 8'd0;
            end
         end else if (b1 && !b3) begin
            step_setting(MODE_SET_SEC, m_sec, m_sec_seen, m_sec_hold, m_sec_fast);
         end else if (b2 && !b3) begin
            step_setting(MODE_SET_MIN, m_min, m_min_seen, m_min_hold, m_min_fast);
         end else if (b3 && !b1 && !b2) begin
            if (m_mode == MODE_COUNTING) begin
               m_paused = 1'b1;
               m_mode   = MODE_PAUSED;
            end else if (m_mode == MODE_PAUSED) begin
               m_paused = 1'b0;
               m_mode   = MODE_COUNTING;
            end
            clear_tracking();
         end else begin
            clear_tracking();
         end
      end else begin
         m_blink = !m_blink;
         hold_tick(b1, m_sec, m_sec_seen, m_sec_hold, m_sec_fast, fs_on);
         hold_tick(b2, m_min, m_min_seen, m_min_hold, m_min_fast, fm_on);

         // start / reset combination
         if (b1 && b2 && !b3) begin
            if (m_combo_seen) begin
               if (m_combo_cnt != HOLD_MAX) m_combo_cnt++;
               if (m_combo_cnt >= cfg_reset_hold) begin
                  m_min     = 6'd0;
                  m_sec     = 6'd0;
                  m_mode    = MODE_IDLE;
                  m_running = 1'b0;
                  m_paused  = 1'b0;
                  clear_tracking();
               end
            end
         end else begin
            if (m_combo_seen && m_combo_cnt < cfg_reset_hold &&
                (m_mode == MODE_IDLE || m_mode == MODE_SET_SEC ||
                 m_mode == MODE_SET_MIN)) begin
               if (m_min == 6'd0 && m_sec == 6'd0) begin
                  refused = 1'b1;
               end else begin
                  m_running = 1'b1;
                  m_paused  = 1'b0;
                  m_mode    = MODE_COUNTING;
                  clear_tracking();
               end
            end
            m_combo_seen = 1'b0;
            m_combo_cnt  = 8'd0;
         end

         // countdown
         if (m_running && !m_paused) begin
            if (m_sec != 6'd0) begin
               m_sec--;
            end else if (m_min != 6'd0) begin
               m_min--;
               m_sec = TIME_TOP;
            end else begin
               m_running = 1'b0;
               m_mode    = MODE_ALARM;
               clear_tracking();
            end
         end

         // leds
         if (m_mode == MODE_COUNTING) begin
            m_led_run   = !m_blink;
            m_led_alarm = 1'b0;
         end else if (m_mode == MODE_ALARM) begin
            m_led_run = 1'b1;
            if (!m_blink) m_led_alarm = !m_led_alarm;
         end else begin
            m_led_run   = 1'b0;
            m_led_alarm = 1'b0;
         end
      end

      r.mode            = m_mode;
      r.minutes_now     = m_min;
      r.seconds_now     = m_sec;
      r.led_run         = m_led_run;
      r.led_alarm       = m_led_alarm;
      r.start_refused   = refused;
      r.all_buttons     = all3;
      r.fast_seconds_on = fs_on;
      r.fast_minutes_on = fm_on;
      pending_readouts.push_back(r);
   endtask

   // drive one request and hold it until accepted; valid stays high on return
   task automatic send_request(input logic tick, input logic [2:0] btn);
      req_tvalid <= 1'b1;
      req_tuser  <= tick;
      req_tdata  <= {5'd0, btn};
      do @(posedge clock); while (!req_tready);
      advance_timer(tick, btn);
      requests_sent++;
   endtask

   // bursts of random length separated by random gaps
   task automatic offer(input logic tick, input logic [2:0] btn);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_request(tick, btn);
   endtask

   // stop sending and wait for every readout, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
   endtask

   task automatic program_timer(input logic [7:0] hold, input logic [7:0] rhold,
                                input logic [5:0] step);
      csr_we    <= 1'b1;
      csr_index <= CSR_HOLD_TICKS;
      csr_wdata <= hold;
      @(posedge clock);
      cfg_hold = hold;
      csr_index <= CSR_RESET_HOLD_TICKS;
      csr_wdata <= rhold;
      @(posedge clock);
      cfg_reset_hold = rhold;
      csr_index <= CSR_FAST_STEP;
      csr_wdata <= {2'b00, step};
      @(posedge clock);
      cfg_step = step;
      csr_we <= 1'b0;
   endtask

   // one short, mostly well-formed button sequence with random content
   task automatic play_scenario();
      int pick, n, k, remaining;
      logic [2:0] held;
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         // set seconds or minutes, possibly into fast stepping
         held = (pick < 18) ? BTN_SEC : BTN_MIN;
         n = $urandom_range(1, 3);
         repeat (n) offer(ACT_POLL, held);
         k = $urandom_range(0, 5);
         repeat (k) begin
            if ($urandom_range(0, 3) == 0) offer(ACT_POLL, held);
            offer(ACT_TICK, held);
         end
         if ($urandom_range(0, 9) < 7) offer(ACT_POLL, BTN_NONE);
      end else if (pick < 48) begin
         // short press to start
         offer(ACT_POLL, BTN_COMBO);
         k = $urandom_range(0, 2);
         repeat (k) offer(ACT_TICK, BTN_COMBO);
         offer(ACT_TICK, ($urandom_range(0, 4) == 0) ? BTN_PAUSE : BTN_NONE);
      end else if (pick < 62) begin
         // let the count run, out to the alarm when the time is short
         remaining = int'(m_min) * 60 + int'(m_sec);
         if (m_running && remaining <= 40) n = remaining + $urandom_range(1, 3);
         else n = $urandom_range(1, 6);
         repeat (n) offer(ACT_TICK, ($urandom_range(0, 5) == 0) ? BTN_PAUSE : BTN_NONE);
      end else if (pick < 70) begin
         // pause and resume
         offer(ACT_POLL, BTN_PAUSE);
         k = $urandom_range(0, 2);
         repeat (k) offer(ACT_TICK, BTN_NONE);
         if ($urandom_range(0, 1) == 1) offer(ACT_POLL, BTN_PAUSE);
      end else if (pick < 78) begin
         // long press back to 00:00, only where the threshold is near
         offer(ACT_POLL, BTN_COMBO);
         n = (cfg_reset_hold <= 12) ? int'(cfg_reset_hold) : $urandom_range(1, 4);
         repeat (n) offer(ACT_TICK, BTN_COMBO);
         offer(ACT_TICK, BTN_NONE);
      end else if (pick < 84) begin
         offer(ACT_POLL, BTN_ALL);
         if ($urandom_range(0, 1) == 1) offer(ACT_TICK, 3'($urandom_range(0, 7)));
      end else begin
         // noise
         n = $urandom_range(1, 4);
         repeat (n) offer(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end
   endtask

   task automatic run_scenarios(input int count);
      int start;
      start = requests_sent;
      while (requests_sent - start < count) play_scenario();
   endtask

   // directed walk through every operation with the reset register values
   task automatic test_directed();
      offer(ACT_TICK, BTN_NONE);
      offer(ACT_POLL, BTN_ALL);
      offer(ACT_POLL, BTN_COMBO);
      offer(ACT_TICK, BTN_NONE);              // start refused at 00:00
      offer(ACT_POLL, BTN_SEC);
      offer(ACT_POLL, BTN_SEC);
      offer(ACT_TICK, BTN_SEC);               // seconds fast stepping begins
      offer(ACT_POLL, BTN_SEC);               // no step while fast
      offer(ACT_POLL, BTN_MIN);
      offer(ACT_TICK, BTN_MIN);               // minutes fast stepping begins
      offer(ACT_POLL, BTN_NONE);
      offer(ACT_POLL, BTN_COMBO);
      offer(ACT_TICK, BTN_NONE);              // start counting
      offer(ACT_POLL, BTN_PAUSE);
      offer(ACT_TICK, BTN_NONE);              // paused, no count
      offer(ACT_POLL, BTN_PAUSE);
      offer(ACT_POLL, BTN_COMBO);
      offer(ACT_TICK, BTN_COMBO);             // long press resets the time
      offer(ACT_POLL, BTN_SEC);
      offer(ACT_POLL, BTN_COMBO);
      offer(ACT_TICK, BTN_NONE);
      offer(ACT_TICK, BTN_NONE);              // reaches zero, alarm
      offer(ACT_TICK, BTN_NONE);
      offer(ACT_TICK, BTN_NONE);
      offer(ACT_POLL, BTN_SEC | BTN_PAUSE);
      drain();
   endtask

   task automatic test_reset_registers();
      run_scenarios(100);
      drain();
   endtask

   // several register settings, the extremes among them
   task automatic test_register_sweep();
      program_timer(8'd1, 8'd1, 6'd59);
      run_scenarios(150);
      drain();

      // hold counts and the combination counted all the way to 255
      program_timer(8'd255, 8'd255, 6'd1);
      offer(ACT_POLL, BTN_SEC);
      repeat (256) offer(ACT_TICK, BTN_SEC);
      offer(ACT_POLL, BTN_COMBO);
      repeat (256) offer(ACT_TICK, BTN_COMBO);
      run_scenarios(30);
      drain();

      program_timer(8'd2, 8'd3, 6'd31);
      run_scenarios(150);
      drain();

      program_timer(8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                    6'($urandom_range(1, 59)));
      run_scenarios(150);
      drain();
   endtask

   // zero thresholds and a step beyond 59
   task automatic test_register_corners();
      program_timer(8'd0, 8'd0, 6'd63);
      run_scenarios(80);
      drain();
   endtask

   // receiver holds off while requests keep coming, so the block backs up
   task automatic test_backpressure();
      program_timer(8'd1, 8'd2, 6'd7);
      long_stall_go = 1'b1;
      repeat (40) send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      drain();
   endtask

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (long_stall_go) begin
         long_stall_go = 1'b0;
         stall_left    = LONG_STALL;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            rx_style      = rx_style_type'($urandom_range(0, 2));
            style_left    = $urandom_range(20, 200);
            ready_pattern = 16'($urandom) | 16'h8001;
         end
         style_left--;
         case (rx_style)
            RX_OPEN: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 2) != 0);
            default: begin
               rsp_tready <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
         endcase
      end
   end

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // compare each readout with the oldest prediction
   always @(posedge clock) begin : check_readout
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[20:0]);
         if (pending_readouts.size() == 0) begin
            fail_count++;
            $error("readout with no request waiting: mode %0d", got.mode);
         end else begin
            want = pending_readouts.pop_front();
            compare_field("mode", int'(want.mode), int'(got.mode));
            compare_field("minutes_now", int'(want.minutes_now), int'(got.minutes_now));
            compare_field("seconds_now", int'(want.seconds_now), int'(got.seconds_now));
            compare_field("led_run", int'(want.led_run), int'(got.led_run));
            compare_field("led_alarm", int'(want.led_alarm), int'(got.led_alarm));
            compare_field("start_refused", int'(want.start_refused),
                          int'(got.start_refused));
            compare_field("all_buttons", int'(want.all_buttons), int'(got.all_buttons));
            compare_field("fast_seconds_on", int'(want.fast_seconds_on),
                          int'(got.fast_seconds_on));
            compare_field("fast_minutes_on", int'(want.fast_minutes_on),
                          int'(got.fast_minutes_on));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset_timer_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_reset_registers();
      test_register_sweep();
      test_register_corners();
      test_backpressure();

      repeat (END_SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_readouts.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
